FILE: sv/timer_table_scheduler_defines.svh
`ifndef TIMER_TABLE_SCHEDULER_DEFINES_SVH
`define TIMER_TABLE_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define TTS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ttsch_pkg.sv
package ttsch_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int RESULT_CAP  = 16;
   localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int NRES_W      = $clog2(RESULT_CAP + 1);

   localparam logic [31:0] ROLLBACK_DEFAULT = 32'd3600000;
   localparam logic [47:0] WAIT_MAX         = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] WAIT_MIN         = 48'h8000_0000_0000;

   localparam logic [2:0] ACT_ADD     = 3'd0;
   localparam logic [2:0] ACT_DELETE  = 3'd1;
   localparam logic [2:0] ACT_REFRESH = 3'd2;
   localparam logic [2:0] ACT_RESET   = 3'd3;
   localparam logic [2:0] ACT_QUERY   = 3'd4;
   localparam logic [2:0] ACT_COLLECT = 3'd5;

   typedef struct packed {
      logic [2:0]  action;
      logic [47:0] now_ms;
      logic [31:0] interval_ms;
      logic        recurring;
      logic        restart;
      logic [47:0] handle;
      logic [15:0] callback_id;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [47:0]        new_handle;
      logic signed [47:0] wait_ms;
      logic               fired;
      logic [15:0]        fired_callback;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        done;
      logic        recurring;
      logic [15:0] callback;
      logic [31:0] interval;
      logic [47:0] expiry;
   } ent_type;

   typedef struct packed {
      logic    shift;
      ent_type wb;
   } ring_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_DECIDE,
      ST_INSERT,
      ST_CALC,
      ST_SUM,
      ST_CHECK,
      ST_APPLY,
      ST_OUT
   } state_type;

   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

endpackage

FILE: sv/timer_table_scheduler.sv
// Timer table scheduler: holds up to TIMER_SLOTS timers keyed by expiry time.
// Input channel req_valid/req_stall/req_data carries one operation per beat
// (add, delete, refresh, reset, query, collect) with the current time.
// Result channel rsp_valid/rsp_stall/rsp_data returns one beat per result;
// the final beat of an item has last set. Collect returns one beat per fired
// timer (at most 16) or a single beat when nothing fires.
// csr_wr_en/csr_wr_data write the rollback threshold; the user must do so
// only while the block is idle; the block does not enforce it. The entries
// sit in a ring of cells that rotates one place per cycle during a table walk.
// Delete, query, a failed add and an unchanged reset take one find walk; add
// then takes an insert walk; refresh and reset compute the new expiry after
// the find walk, then take a check walk and an apply walk. Collect takes a
// find walk, a check walk (skipped for a one-shot timer) and an apply walk
// per fired timer, plus a closing find walk unless the result cap was reached.
// One item is worked at a time; req_stall stays high until its last beat is
// loaded into the output register, and the next item can be taken in the
// following cycle. Reset empties the table, clears the stored previous time
// and restores the default threshold. A stalled result holds in the output
// register and the block waits before loading the next one.
module timer_table_scheduler import ttsch_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   ring_ctl_type ctl;
   ent_type      chain [TIMER_SLOTS+1];

   assign chain[0] = ctl.wb;

   for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
      ttsch_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (ctl.shift),
         .d     (chain[i]),
         .q     (chain[i+1])
      );
   end

   ttsch_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (chain[TIMER_SLOTS]),
      .ctl         (ctl)
   );

endmodule

FILE: sv/ttsch_cell.sv
module ttsch_cell import ttsch_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    shift,
   input  ent_type d,
   output ent_type q
);

   logic    valid_ff;
   ent_type ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         ent_ff <= d;
      end
   end

   always_comb begin
      q       = ent_ff;
      q.valid = valid_ff;
   end

endmodule

FILE: sv/ttsch_ctrl.sv
module ttsch_ctrl import ttsch_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   input  ent_type      head,
   output ring_ctl_type ctl
);

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  cnt_ff, cnt_in;
   logic [NRES_W-1:0]  nres_ff, nres_in;
   req_type            req_ff, req_in;
   logic [31:0]        thr_ff, thr_in;
   logic [47:0]        prev_ff, prev_in;
   logic               roll_ff, roll_in;
   logic               first_ff, first_in;
   logic               free_ff, free_in;
   logic               hit_ff, hit_in;
   logic               found_ff, found_in;
   logic               have_ff, have_in;
   logic               ins_ff, ins_in;
   logic               pend_ff, pend_in;
   logic [47:0]        key_ff, key_in;
   logic [47:0]        sel_exp_ff, sel_exp_in;
   logic [31:0]        sel_int_ff, sel_int_in;
   logic               sel_rec_ff, sel_rec_in;
   logic [15:0]        sel_cb_ff, sel_cb_in;
   logic [47:0]        base_ff, base_in;
   logic [31:0]        addend_ff, addend_in;
   logic [47:0]        tgt_ff, tgt_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               out_free;
   logic               pass_end;
   logic               self_hit;
   logic               cand;
   logic signed [48:0] diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= ROLLBACK_DEFAULT;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      nres_ff    <= nres_in;
      req_ff     <= req_in;
      roll_ff    <= roll_in;
      first_ff   <= first_in;
      free_ff    <= free_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
      have_ff    <= have_in;
      ins_ff     <= ins_in;
      pend_ff    <= pend_in;
      key_ff     <= key_in;
      sel_exp_ff <= sel_exp_in;
      sel_int_ff <= sel_int_in;
      sel_rec_ff <= sel_rec_in;
      sel_cb_ff  <= sel_cb_in;
      base_ff    <= base_in;
      addend_ff  <= addend_in;
      tgt_ff     <= tgt_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      nres_in      = nres_ff;
      req_in       = req_ff;
      thr_in       = csr_wr_en ? csr_wr_data : thr_ff;
      prev_in      = prev_ff;
      roll_in      = roll_ff;
      first_in     = first_ff;
      free_in      = free_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      have_in      = have_ff;
      ins_in       = ins_ff;
      pend_in      = pend_ff;
      key_in       = key_ff;
      sel_exp_in   = sel_exp_ff;
      sel_int_in   = sel_int_ff;
      sel_rec_in   = sel_rec_ff;
      sel_cb_in    = sel_cb_ff;
      base_in      = base_ff;
      addend_in    = addend_ff;
      tgt_in       = tgt_ff;
      res_in       = res_ff;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctl.shift    = 1'b0;
      ctl.wb       = head;
      pass_end     = (cnt_ff == SLOT_W'(TIMER_SLOTS - 1));
      self_hit     = head.valid && (head.expiry == key_ff);
      cand         = head.valid &&
                     ((req_ff.action != ACT_COLLECT) || first_ff || !head.done);
      diff         = $signed({1'b0, sel_exp_ff}) - $signed({1'b0, req_ff.now_ms});

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               key_in   = req_data.handle;
               tgt_in   = sat_add48(req_data.now_ms, req_data.interval_ms);
               cnt_in   = '0;
               nres_in  = '0;
               first_in = 1'b1;
               pend_in  = 1'b0;
               have_in  = 1'b0;
               free_in  = 1'b0;
               hit_in   = 1'b0;
               found_in = 1'b0;
               ins_in   = 1'b0;
               if (req_data.action == ACT_COLLECT) begin
                  roll_in = ({1'b0, req_data.now_ms} + {17'd0, thr_ff}) < {1'b0, prev_ff};
                  prev_in = req_data.now_ms;
               end
               if (req_data.action <= ACT_COLLECT) begin
                  state_in = ST_FIND;
               end else begin
                  res_in      = '0;
                  res_in.last = 1'b1;
                  state_in    = ST_OUT;
               end
            end
         end
         ST_FIND: begin
            ctl.shift = 1'b1;
            cnt_in    = pass_end ? '0 : cnt_ff + SLOT_W'(1);
            if (pass_end) begin
               state_in = ST_DECIDE;
            end
            case (req_ff.action) inside
               ACT_ADD: begin
                  free_in = free_ff || !head.valid;
                  hit_in  = hit_ff || (head.valid && head.expiry == tgt_ff);
               end
               ACT_DELETE: begin
                  if (self_hit) begin
                     ctl.wb.valid = 1'b0;
                     found_in     = 1'b1;
                  end
               end
               ACT_REFRESH, ACT_RESET: begin
                  if (self_hit) begin
                     found_in   = 1'b1;
                     sel_exp_in = head.expiry;
                     sel_int_in = head.interval;
                  end
               end
               ACT_QUERY, ACT_COLLECT: begin
                  if (req_ff.action == ACT_COLLECT && first_ff) begin
                     ctl.wb.done = 1'b0;
                  end
                  if (cand && (!have_ff || head.expiry < sel_exp_ff)) begin
                     have_in    = 1'b1;
                     sel_exp_in = head.expiry;
                     sel_int_in = head.interval;
                     sel_rec_in = head.recurring;
                     sel_cb_in  = head.callback;
                  end
               end
               default: ;
            endcase
         end
         ST_DECIDE: begin
            res_in      = '0;
            res_in.last = 1'b1;
            state_in    = ST_OUT;
            case (req_ff.action) inside
               ACT_ADD: begin
                  if (!free_ff || hit_ff) begin
                     res_in.new_handle = '1;
                  end else begin
                     state_in = ST_INSERT;
                  end
               end
               ACT_DELETE: begin
                  res_in.ok = found_ff;
               end
               ACT_REFRESH, ACT_RESET: begin
                  if (found_ff) begin
                     if (req_ff.action == ACT_RESET && sel_int_ff == req_ff.interval_ms &&
                         !req_ff.restart) begin
                        res_in.ok         = 1'b1;
                        res_in.new_handle = req_ff.handle;
                     end else begin
                        state_in = ST_CALC;
                     end
                  end
               end
               ACT_QUERY: begin
                  if (!have_ff) begin
                     res_in.wait_ms = WAIT_MAX;
                  end else begin
                     res_in.ok = 1'b1;
                     if (diff[48] != diff[47]) begin
                        res_in.wait_ms = diff[48] ? WAIT_MIN : WAIT_MAX;
                     end else begin
                        res_in.wait_ms = diff[47:0];
                     end
                  end
               end
               ACT_COLLECT: begin
                  if (have_ff && (roll_ff || sel_exp_ff <= req_ff.now_ms)) begin
                     key_in   = sel_exp_ff;
                     res_in   = res_ff;
                     state_in = pend_ff ? ST_OUT : ST_CALC;
                  end else if (pend_ff) begin
                     res_in      = res_ff;
                     res_in.last = 1'b1;
                  end else begin
                     res_in.ok = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_INSERT: begin
            ctl.shift = 1'b1;
            cnt_in    = pass_end ? '0 : cnt_ff + SLOT_W'(1);
            if (!head.valid && !ins_ff) begin
               ctl.wb.valid     = 1'b1;
               ctl.wb.done      = 1'b0;
               ctl.wb.recurring = req_ff.recurring;
               ctl.wb.callback  = req_ff.callback_id;
               ctl.wb.interval  = req_ff.interval_ms;
               ctl.wb.expiry    = tgt_ff;
               ins_in           = 1'b1;
            end
            if (pass_end) begin
               res_in            = '0;
               res_in.ok         = 1'b1;
               res_in.new_handle = tgt_ff;
               res_in.last       = 1'b1;
               state_in          = ST_OUT;
            end
         end
         ST_CALC: begin
            if (req_ff.action == ACT_RESET) begin
               addend_in = req_ff.interval_ms;
               if (req_ff.restart) begin
                  base_in = req_ff.now_ms;
               end else if (sel_exp_ff >= {16'd0, sel_int_ff}) begin
                  base_in = sel_exp_ff - {16'd0, sel_int_ff};
               end else begin
                  base_in = '0;
               end
            end else begin
               base_in   = req_ff.now_ms;
               addend_in = sel_int_ff;
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            tgt_in   = sat_add48(base_ff, addend_ff);
            hit_in   = 1'b0;
            state_in = (req_ff.action == ACT_COLLECT && !sel_rec_ff) ? ST_APPLY : ST_CHECK;
         end
         ST_CHECK: begin
            ctl.shift = 1'b1;
            cnt_in    = pass_end ? '0 : cnt_ff + SLOT_W'(1);
            if (head.valid && head.expiry == tgt_ff && head.expiry != key_ff) begin
               hit_in = 1'b1;
            end
            if (pass_end) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            ctl.shift = 1'b1;
            cnt_in    = pass_end ? '0 : cnt_ff + SLOT_W'(1);
            if (self_hit) begin
               if (req_ff.action == ACT_COLLECT) begin
                  ctl.wb.done = 1'b1;
                  if (!sel_rec_ff || hit_ff) begin
                     ctl.wb.valid = 1'b0;
                  end else begin
                     ctl.wb.expiry = tgt_ff;
                  end
               end else begin
                  if (hit_ff) begin
                     ctl.wb.valid = 1'b0;
                  end else begin
                     ctl.wb.expiry = tgt_ff;
                  end
                  if (req_ff.action == ACT_RESET) begin
                     ctl.wb.interval = req_ff.interval_ms;
                  end
               end
            end
            if (pass_end) begin
               res_in    = '0;
               res_in.ok = 1'b1;
               if (req_ff.action == ACT_COLLECT) begin
                  res_in.fired          = 1'b1;
                  res_in.fired_callback = sel_cb_ff;
                  res_in.new_handle     = (sel_rec_ff && !hit_ff) ? tgt_ff : '0;
                  pend_in               = 1'b1;
                  nres_in               = nres_ff + NRES_W'(1);
                  if (nres_ff == NRES_W'(RESULT_CAP - 1)) begin
                     res_in.last = 1'b1;
                     state_in    = ST_OUT;
                  end else begin
                     first_in = 1'b0;
                     have_in  = 1'b0;
                     state_in = ST_FIND;
                  end
               end else begin
                  res_in.new_handle = tgt_ff;
                  res_in.last       = 1'b1;
                  state_in          = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               pend_in      = 1'b0;
               state_in     = res_ff.last ? ST_IDLE : ST_CALC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/ttsch_checker.sv
`include "timer_table_scheduler_defines.svh"

module ttsch_checker import ttsch_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `TTS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled beat changed")
   `TTS_ASSERT_NXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall, "second item taken while busy")
   `TTS_ASSERT_IMP(a_mid_fired, clock, reset, rsp_valid && !rsp_data.last, rsp_data.fired, "non-final beat without fired timer")
   `TTS_ASSERT_IMP(a_fired_ok, clock, reset, rsp_valid && rsp_data.fired, rsp_data.ok, "fired beat without ok")

endmodule

bind timer_table_scheduler ttsch_checker u_ttsch_checker (.*);

FILE: dv/tb_timer_table_scheduler.sv
module tb_timer_table_scheduler;
   import ttsch_pkg::*;

   localparam int STEP_LIMIT = 1500000;
   localparam int SETTLE     = 4 * TIMER_SLOTS + 16;

   class timer_scoreboard;
      bit          live [TIMER_SLOTS];
      logic [47:0] expiry [TIMER_SLOTS];
      logic [31:0] period [TIMER_SLOTS];
      bit          repeats [TIMER_SLOTS];
      logic [15:0] callback [TIMER_SLOTS];
      logic [47:0] last_now;
      logic [31:0] rollback;
      rsp_type     due_rsp [$];
      int          errors;

      function new();
         last_now = '0;
         rollback = ROLLBACK_DEFAULT;
         errors = 0;
         foreach (live[i]) live[i] = 0;
      endfunction

      function logic [47:0] clamp_sum(logic [47:0] a, logic [31:0] b);
         logic [48:0] s;
         s = {1'b0, a} + {17'd0, b};
         return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
      endfunction

      function int slot_of(logic [47:0] t);
         for (int i = 0; i < TIMER_SLOTS; i++)
            if (live[i] && expiry[i] == t) return i;
         return -1;
      endfunction

      // drop the timer if another one already holds the new expiry
      function bit move_timer(int s, logic [47:0] t);
         for (int i = 0; i < TIMER_SLOTS; i++)
            if (i != s && live[i] && expiry[i] == t) begin
               live[s] = 0;
               return 0;
            end
         expiry[s] = t;
         return 1;
      endfunction

      function void push(logic ok, logic [47:0] nh, logic [47:0] w, logic fired,
                         logic [15:0] cb, logic last);
         rsp_type r;
         r.ok = ok;
         r.new_handle = nh;
         r.wait_ms = w;
         r.fired = fired;
         r.fired_callback = cb;
         r.last = last;
         due_rsp.insert(due_rsp.size(), r);
      endfunction

      function void note_request(req_type q);
         int s;
         int m;
         int n;
         logic [47:0] t;
         logic [47:0] start;
         longint w;
         bit roll;
         bit done [TIMER_SLOTS];
         case (q.action)
            ACT_ADD: begin
               t = clamp_sum(q.now_ms, q.interval_ms);
               s = -1;
               for (int i = TIMER_SLOTS - 1; i >= 0; i--)
                  if (!live[i]) s = i;
               if (s < 0 || slot_of(t) >= 0) begin
                  push(0, '1, 0, 0, 0, 1);
               end else begin
                  live[s] = 1;
                  expiry[s] = t;
                  period[s] = q.interval_ms;
                  repeats[s] = q.recurring;
                  callback[s] = q.callback_id;
                  push(1, t, 0, 0, 0, 1);
               end
            end
            ACT_DELETE: begin
               s = slot_of(q.handle);
               if (s >= 0) live[s] = 0;
               push(s >= 0, 0, 0, 0, 0, 1);
            end
            ACT_REFRESH: begin
               s = slot_of(q.handle);
               if (s < 0) begin
                  push(0, 0, 0, 0, 0, 1);
               end else begin
                  t = clamp_sum(q.now_ms, period[s]);
                  void'(move_timer(s, t));
                  push(1, t, 0, 0, 0, 1);
               end
            end
            ACT_RESET: begin
               s = slot_of(q.handle);
               if (s < 0) begin
                  push(0, 0, 0, 0, 0, 1);
               end else if (period[s] == q.interval_ms && !q.restart) begin
                  push(1, q.handle, 0, 0, 0, 1);
               end else begin
                  if (q.restart) start = q.now_ms;
                  else if (expiry[s] >= {16'd0, period[s]}) start = expiry[s] - period[s];
                  else start = '0;
                  period[s] = q.interval_ms;
                  t = clamp_sum(start, q.interval_ms);
                  void'(move_timer(s, t));
                  push(1, t, 0, 0, 0, 1);
               end
            end
            ACT_QUERY: begin
               m = -1;
               for (int i = 0; i < TIMER_SLOTS; i++)
                  if (live[i] && (m < 0 || expiry[i] < expiry[m])) m = i;
               if (m < 0) begin
                  push(0, 0, WAIT_MAX, 0, 0, 1);
               end else begin
                  w = longint'({16'd0, expiry[m]}) - longint'({16'd0, q.now_ms});
                  if (w > longint'(64'h7FFF_FFFF_FFFF)) w = 64'h7FFF_FFFF_FFFF;
                  if (w < -longint'(64'h8000_0000_0000)) w = -longint'(64'h8000_0000_0000);
                  push(1, 0, w[47:0], 0, 0, 1);
               end
            end
            ACT_COLLECT: begin
               roll = ({16'd0, q.now_ms} + {32'd0, rollback}) < {16'd0, last_now};
               last_now = q.now_ms;
               foreach (done[i]) done[i] = 0;
               n = 0;
               while (n < RESULT_CAP) begin
                  m = -1;
                  for (int i = 0; i < TIMER_SLOTS; i++)
                     if (live[i] && !done[i] && (m < 0 || expiry[i] < expiry[m])) m = i;
                  if (m < 0) break;
                  if (!(roll || expiry[m] <= q.now_ms)) break;
                  done[m] = 1;
                  t = '0;
                  if (repeats[m]) begin
                     if (!move_timer(m, clamp_sum(q.now_ms, period[m]))) t = '0;
                     else t = expiry[m];
                  end else begin
                     live[m] = 0;
                  end
                  push(1, t, 0, 1, callback[m], 0);
                  n++;
               end
               if (n == 0) push(1, 0, 0, 0, 0, 1);
               else due_rsp[due_rsp.size() - 1].last = 1;
            end
            default: push(0, 0, 0, 0, 0, 1);
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_rsp.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
            return;
         end
         want = due_rsp.pop_front();
         if (got.ok !== want.ok)
            $display("%0t: ok expected %h actual %h", $time, want.ok, got.ok);
         if (got.new_handle !== want.new_handle)
            $display("%0t: new_handle expected %h actual %h", $time,
                     want.new_handle, got.new_handle);
         if (got.wait_ms !== want.wait_ms)
            $display("%0t: wait_ms expected %h actual %h", $time, want.wait_ms, got.wait_ms);
         if (got.fired !== want.fired)
            $display("%0t: fired expected %h actual %h", $time, want.fired, got.fired);
         if (got.fired_callback !== want.fired_callback)
            $display("%0t: fired_callback expected %h actual %h", $time,
                     want.fired_callback, got.fired_callback);
         if (got.last !== want.last)
            $display("%0t: last expected %h actual %h", $time, want.last, got.last);
         if (got !== want) errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   timer_scoreboard sb = new();
   bit          req_gaps = 1;
   bit          rsp_gaps = 1;
   int          hold_cycles = 0;
   int          cycle_count = 0;
   logic [47:0] clock_ms = 48'd1000;

   timer_table_scheduler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > STEP_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: check accepted beats, then pick the next stall
   initial begin
      rsp_stall = 1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= rsp_gaps && ($urandom_range(99) < 38);
         end
      end
   end

   task automatic send_beat(req_type q);
      if (req_gaps && $urandom_range(99) < 38) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 38);
      end
      req_valid <= 1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      sb.note_request(q);
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (sb.due_rsp.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_threshold(logic [31:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.rollback = v;
   endtask

   task automatic send_op(logic [2:0] a, logic [47:0] now, logic [31:0] iv, bit rec,
                          bit fnow, logic [47:0] h, logic [15:0] cb);
      req_type q;
      q.action = a;
      q.now_ms = now;
      q.interval_ms = iv;
      q.recurring = rec;
      q.restart = fnow;
      q.handle = h;
      q.callback_id = cb;
      send_beat(q);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic send_random();
      req_type q;
      int pick;
      int s;
      pick = $urandom_range(99);
      if (pick < 32) q.action = ACT_ADD;
      else if (pick < 42) q.action = ACT_DELETE;
      else if (pick < 53) q.action = ACT_REFRESH;
      else if (pick < 65) q.action = ACT_RESET;
      else if (pick < 74) q.action = ACT_QUERY;
      else if (pick < 96) q.action = ACT_COLLECT;
      else q.action = 3'(6 + $urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 4) clock_ms = rand48();
      else if (pick < 8) clock_ms = clock_ms - $urandom_range(20000000);
      else clock_ms = clock_ms + $urandom_range(40);
      q.now_ms = clock_ms;
      q.interval_ms = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
      q.recurring = 1'($urandom_range(1));
      q.restart = 1'($urandom_range(1));
      q.handle = rand48();
      s = $urandom_range(TIMER_SLOTS - 1);
      if ($urandom_range(9) < 8 && sb.live[s]) q.handle = sb.expiry[s];
      q.callback_id = 16'($urandom);
      send_beat(q);
   endtask

   initial begin
      logic [31:0] levels [5];
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_op(ACT_QUERY, 0, 0, 0, 0, 0, 0);
      send_op(ACT_COLLECT, 0, 0, 0, 0, 0, 0);
      send_op(ACT_ADD, 1000, 0, 0, 0, 0, 16'hFFFF);
      send_op(ACT_ADD, 1000, 0, 1, 0, 0, 16'h0001);
      send_op(ACT_ADD, '1, '1, 1, 1, '1, 16'h0000);
      send_op(ACT_ADD, 100, 50, 1, 0, 0, 16'h0001);
      send_op(ACT_ADD, 100, 60, 0, 0, 0, 16'h0002);
      send_op(ACT_QUERY, 0, 0, 0, 0, 0, 0);
      send_op(ACT_QUERY, '1, 0, 0, 0, 0, 0);
      send_op(ACT_REFRESH, 110, 0, 0, 0, 150, 0);
      send_op(ACT_ADD, 100, 50, 1, 0, 0, 16'h0003);
      send_op(ACT_RESET, 120, 50, 0, 0, 150, 0);
      send_op(ACT_RESET, 120, 80, 0, 0, 150, 0);
      send_op(ACT_RESET, 200, 10, 0, 1, 180, 0);
      send_op(ACT_RESET, 200, 10, 0, 1, 12345, 0);
      send_op(ACT_DELETE, 200, 0, 0, 0, 1000, 0);
      send_op(ACT_DELETE, 200, 0, 0, 0, 1000, 0);
      send_op(ACT_REFRESH, 200, 0, 0, 0, 999, 0);
      send_op(3'd6, '1, '1, 1, 1, '1, '1);
      send_op(3'd7, 0, 0, 0, 0, 0, 0);
      send_op(ACT_ADD, 250, 0, 1, 0, 0, 16'h00AA);
      send_op(ACT_COLLECT, 300, 0, 0, 0, 0, 0);
      send_op(ACT_COLLECT, 10, 0, 0, 0, 0, 0);
      drain();

      levels[0] = 32'd0;
      levels[1] = 32'hFFFF_FFFF;
      levels[2] = 32'd50;
      levels[3] = $urandom;
      levels[4] = ROLLBACK_DEFAULT;
      for (int p = 0; p < 5; p++) begin
         write_threshold(levels[p]);
         req_gaps = (p != 2);
         rsp_gaps = (p != 2);
         if (p == 1) hold_cycles = 600;
         for (int k = 0; k < 78; k++) begin
            if (k == 40) drain();
            send_random();
         end
         drain();
      end

      if (sb.errors == 0 && sb.due_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
